// ----- rtl/core/tcse_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tcse_pkg;

  // Default screen geometry.
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Field widths fixed by the command and result formats.
  localparam int KIND_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int POS_W   = 11;
  localparam int CELL_W  = 16;
  localparam int COLOR_W = 4;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  // Character codes and the attribute used by the power-on clear.
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] RESET_ATTR   = 8'h0F;

  // Register select, taken from the word address bit of paddr.
  localparam logic REG_FG = 1'b0;
  localparam logic REG_BG = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUT,
    KIND_CLEAR,
    KIND_SETCUR,
    KIND_READ
  } kind_t;

  // Datapath operations selected by the control word.
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_FILL_RESET,
    OP_PUT,
    OP_READ_UP,
    OP_COPY,
    OP_FILL_BLANK,
    OP_SCROLL_END,
    OP_HOME,
    OP_SETC,
    OP_ROW_STEP,
    OP_NOP
  } op_t;

  // Branch conditions of the microprogram.
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_DISPATCH,
    C_PUT_OVER,
    C_MORE_COPY,
    C_MORE_FILL,
    C_ROW_AHEAD
  } cond_t;

  // Microprogram addresses.
  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_PUT,
    S_SCR_RD,
    S_SCR_WR,
    S_SCR_FILL,
    S_SCR_END,
    S_CLR_FILL,
    S_CLR_END,
    S_SETC,
    S_SETC_ROW,
    S_READ
  } step_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t tgt_t;
    step_t tgt_f;
  } ucode_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    op_t  op;
    logic accept;
    logic done;
  } ctl_t;

  // Status from the datapath back to the sequencer.
  typedef struct packed {
    logic put_over;
    logic ptr_copy_last;
    logic ptr_last;
    logic row_ahead;
  } stat_t;

  // The control store: one word per step, jump to tgt_t when the
  // condition holds, else to tgt_f (a dispatch goes to the command entry).
  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    case (s)
      S_IDLE:     w = '{OP_IDLE,       C_DISPATCH,  S_IDLE,     S_IDLE};
      S_INIT:     w = '{OP_FILL_RESET, C_MORE_FILL, S_INIT,     S_IDLE};
      S_PUT:      w = '{OP_PUT,        C_PUT_OVER,  S_SCR_RD,   S_IDLE};
      S_SCR_RD:   w = '{OP_READ_UP,    C_ALWAYS,    S_SCR_WR,   S_SCR_WR};
      S_SCR_WR:   w = '{OP_COPY,       C_MORE_COPY, S_SCR_RD,   S_SCR_FILL};
      S_SCR_FILL: w = '{OP_FILL_BLANK, C_MORE_FILL, S_SCR_FILL, S_SCR_END};
      S_SCR_END:  w = '{OP_SCROLL_END, C_ALWAYS,    S_IDLE,     S_IDLE};
      S_CLR_FILL: w = '{OP_FILL_BLANK, C_MORE_FILL, S_CLR_FILL, S_CLR_END};
      S_CLR_END:  w = '{OP_HOME,       C_ALWAYS,    S_IDLE,     S_IDLE};
      S_SETC:     w = '{OP_SETC,       C_ALWAYS,    S_SETC_ROW, S_SETC_ROW};
      S_SETC_ROW: w = '{OP_ROW_STEP,   C_ROW_AHEAD, S_SETC_ROW, S_IDLE};
      S_READ:     w = '{OP_NOP,        C_ALWAYS,    S_IDLE,     S_IDLE};
      default:    w = '{OP_NOP,        C_ALWAYS,    S_IDLE,     S_IDLE};
    endcase
    return w;
  endfunction

  // Entry point of each command.
  function automatic step_t entry_of(kind_t k);
    step_t s;
    case (k)
      KIND_PUT:    s = S_PUT;
      KIND_CLEAR:  s = S_CLR_FILL;
      KIND_SETCUR: s = S_SETC;
      KIND_READ:   s = S_READ;
      default:     s = S_IDLE;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tcse_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcse_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one read port with registered data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/tcse_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcse_seq (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [tcse_pkg::KIND_W-1:0] kind,
  input  wire tcse_pkg::stat_t             stat,
  output tcse_pkg::ctl_t                   ctl,
  output logic                             busy
);

  tcse_pkg::step_t  step;
  tcse_pkg::step_t  step_next;
  tcse_pkg::ucode_t uw;
  logic             taken;

  // Fetch the control word of the current step.
  assign uw = tcse_pkg::ucode_rom(step);

  // Evaluate the branch condition.
  always_comb begin
    case (uw.cond)
      tcse_pkg::C_ALWAYS:    taken = 1'b1;
      tcse_pkg::C_DISPATCH:  taken = start;
      tcse_pkg::C_PUT_OVER:  taken = stat.put_over;
      tcse_pkg::C_MORE_COPY: taken = !stat.ptr_copy_last;
      tcse_pkg::C_MORE_FILL: taken = !stat.ptr_last;
      tcse_pkg::C_ROW_AHEAD: taken = stat.row_ahead;
      default:               taken = 1'b0;
    endcase
  end

  // Next step address; a dispatch jumps to the entry of the command.
  always_comb begin
    if (uw.cond == tcse_pkg::C_DISPATCH) begin
      step_next = taken ? tcse_pkg::entry_of(tcse_pkg::kind_t'(kind)) : uw.tgt_f;
    end else begin
      step_next = taken ? uw.tgt_t : uw.tgt_f;
    end
  end

  assign busy       = (step != tcse_pkg::S_IDLE);
  assign ctl.op     = uw.op;
  assign ctl.accept = (step == tcse_pkg::S_IDLE) && start;
  // A command finishes on the step that returns to idle; the power-on
  // clearing pass produces no result.
  assign ctl.done   = busy && (step != tcse_pkg::S_INIT) && (step_next == tcse_pkg::S_IDLE);

  // Step counter; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= tcse_pkg::S_INIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/tcse_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcse_datapath #(
  parameter int COLUMNS = tcse_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcse_pkg::ROWS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire tcse_pkg::ctl_t               ctl,
  output tcse_pkg::stat_t                   stat,
  input  wire logic [tcse_pkg::COLOR_W-1:0] fg_color,
  input  wire logic [tcse_pkg::COLOR_W-1:0] bg_color,
  input  wire logic [tcse_pkg::KIND_W-1:0]  kind,
  input  wire logic [tcse_pkg::CHAR_W-1:0]  char_code,
  input  wire logic [tcse_pkg::POS_W-1:0]   position,
  output logic                              done,
  output logic [tcse_pkg::POS_W-1:0]        cursor_now,
  output logic [tcse_pkg::CELL_W-1:0]       cell_data,
  output logic                              scrolled
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int LAST  = CELLS - COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int IW    = AW + 1;
  localparam int EW    = (IW > tcse_pkg::POS_W) ? IW : tcse_pkg::POS_W;
  localparam logic [tcse_pkg::CELL_W-1:0] RESET_CELL = {tcse_pkg::RESET_ATTR, tcse_pkg::CH_SPACE};

  logic [IW-1:0]                  cursor;
  logic [IW-1:0]                  cursor_next;
  logic [IW-1:0]                  row_base;
  logic [IW-1:0]                  row_base_next;
  logic [IW-1:0]                  row_end;
  logic [IW-1:0]                  cursor_inc;
  logic [AW-1:0]                  ptr;
  logic [AW-1:0]                  ptr_next;
  tcse_pkg::kind_t                kind_q;
  logic [tcse_pkg::CHAR_W-1:0]    char_q;
  logic [tcse_pkg::POS_W-1:0]     pos_q;
  logic                           pos_ok_q;
  logic                           pos_ok;
  logic [tcse_pkg::CHAR_W-1:0]    attr;
  logic [tcse_pkg::CELL_W-1:0]    blank;
  logic                           we;
  logic [AW-1:0]                  waddr;
  logic [tcse_pkg::CELL_W-1:0]    wdata;
  logic [AW-1:0]                  raddr;
  logic [tcse_pkg::CELL_W-1:0]    rdata;

  // Cell attribute and the blank cell of the current colours.
  assign attr  = {bg_color, fg_color};
  assign blank = {attr, tcse_pkg::CH_SPACE};

  // A cell index on the position port is valid only below the cell count.
  assign pos_ok = EW'(position) < EW'(CELLS);

  assign row_end    = row_base + IW'(COLUMNS);
  assign cursor_inc = cursor + IW'(1);

  // Status for the branch conditions.
  assign stat.put_over      = cursor_next >= IW'(CELLS);
  assign stat.ptr_copy_last = ptr == AW'(LAST - 1);
  assign stat.ptr_last      = ptr == AW'(CELLS - 1);
  assign stat.row_ahead     = cursor >= row_end;

  // Datapath operation of the current control word.
  always_comb begin
    cursor_next   = cursor;
    row_base_next = row_base;
    ptr_next      = ptr;
    we            = 1'b0;
    waddr         = ptr;
    wdata         = blank;
    raddr         = ptr;
    case (ctl.op)
      tcse_pkg::OP_IDLE: begin
        // Look up the cell now so that its data is ready in the read step.
        ptr_next = '0;
        raddr    = pos_ok ? AW'(position) : '0;
      end
      tcse_pkg::OP_FILL_RESET: begin
        we       = 1'b1;
        wdata    = RESET_CELL;
        ptr_next = ptr + AW'(1);
      end
      tcse_pkg::OP_PUT: begin
        if (char_q == tcse_pkg::CH_NEWLINE) begin
          cursor_next   = row_end;
          row_base_next = row_end;
        end else if (char_q == tcse_pkg::CH_BACKSPACE) begin
          if (cursor != '0) begin
            cursor_next = cursor - IW'(1);
            we          = 1'b1;
            waddr       = AW'(cursor - IW'(1));
            if (cursor == row_base) begin
              row_base_next = row_base - IW'(COLUMNS);
            end
          end
        end else begin
          we          = 1'b1;
          waddr       = AW'(cursor);
          wdata       = {attr, char_q};
          cursor_next = cursor_inc;
          if (cursor_inc == row_end) begin
            row_base_next = row_end;
          end
        end
      end
      tcse_pkg::OP_READ_UP: begin
        raddr = ptr + AW'(COLUMNS);
      end
      tcse_pkg::OP_COPY: begin
        we       = 1'b1;
        wdata    = rdata;
        ptr_next = ptr + AW'(1);
      end
      tcse_pkg::OP_FILL_BLANK: begin
        we       = 1'b1;
        ptr_next = ptr + AW'(1);
      end
      tcse_pkg::OP_SCROLL_END: begin
        cursor_next   = IW'(LAST);
        row_base_next = IW'(LAST);
      end
      tcse_pkg::OP_HOME: begin
        cursor_next   = '0;
        row_base_next = '0;
      end
      tcse_pkg::OP_SETC: begin
        // Saturate to the last cell, then find the row start step by step.
        cursor_next   = pos_ok_q ? IW'(pos_q) : IW'(CELLS - 1);
        row_base_next = '0;
      end
      tcse_pkg::OP_ROW_STEP: begin
        if (stat.row_ahead) begin
          row_base_next = row_end;
        end
      end
      default: begin
      end
    endcase
  end

  // Cursor, row start and sweep pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor   <= '0;
      row_base <= '0;
      ptr      <= '0;
    end else begin
      cursor   <= cursor_next;
      row_base <= row_base_next;
      ptr      <= ptr_next;
    end
  end

  // Command fields are held for the length of the command.
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      kind_q   <= tcse_pkg::kind_t'(kind);
      char_q   <= char_code;
      pos_q    <= position;
      pos_ok_q <= pos_ok;
    end
  end

  // Result register and its one-cycle strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.done;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.done) begin
      cursor_now <= tcse_pkg::POS_W'(cursor_next);
      cell_data  <= (kind_q == tcse_pkg::KIND_READ && pos_ok_q) ? rdata : '0;
      scrolled   <= (ctl.op == tcse_pkg::OP_SCROLL_END);
    end
  end

  tcse_ram #(
    .WIDTH(tcse_pkg::CELL_W),
    .DEPTH(CELLS)
  ) u_screen (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

endmodule

`default_nettype wire

// ----- rtl/core/text_console_screen_engine.sv -----
// Text console screen engine: a COLUMNS x ROWS screen of 16-bit cells
// (attribute high byte, character low byte) and a cursor, driven by a
// microcoded sequencer over one screen RAM. A command is taken when start is
// high and busy is low; its result is shown for exactly one cycle with done
// high and is not held, so the receiver must take it then. A put of an
// ordinary character, newline or backspace and a cell read each finish
// without a sweep of the screen, and the next command may be given in the
// cycle that done is high. A put that scrolls walks the RAM port once per
// cell read and once per cell write as it moves the screen up a row, then
// blanks the last row. A clear writes one cell a cycle. A set-cursor finds
// the row start by repeated addition. After reset the block clears the
// screen one cell a cycle and holds busy high until the clearing pass is
// done; the colour registers can be written during that time.
`timescale 1ns / 1ps
`default_nettype none

module text_console_screen_engine #(
  parameter int COLUMNS = tcse_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcse_pkg::ROWS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Command channel
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [tcse_pkg::KIND_W-1:0] kind,
  input  wire logic [tcse_pkg::CHAR_W-1:0] char_code,
  input  wire logic [tcse_pkg::POS_W-1:0]  position,
  // Result channel
  output logic                             done,
  output logic [tcse_pkg::POS_W-1:0]       cursor_now,
  output logic [tcse_pkg::CELL_W-1:0]      cell_data,
  output logic                             scrolled,
  // Register port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tcse_pkg::APB_AW-1:0] paddr,
  input  wire logic [tcse_pkg::APB_DW-1:0] pwdata,
  output logic [tcse_pkg::APB_DW-1:0]      prdata,
  output logic                             pready
);

  localparam int LAST = COLUMNS * ROWS - COLUMNS;

  tcse_pkg::ctl_t               ctl;
  tcse_pkg::stat_t              stat;
  logic [tcse_pkg::COLOR_W-1:0] fg_color;
  logic [tcse_pkg::COLOR_W-1:0] bg_color;
  logic                         reg_write;

  // Colour registers; the word address bit selects the register.
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color <= tcse_pkg::COLOR_W'(15);
      bg_color <= '0;
    end else if (reg_write) begin
      if (paddr[2] == tcse_pkg::REG_BG) begin
        bg_color <= pwdata[tcse_pkg::COLOR_W-1:0];
      end else begin
        fg_color <= pwdata[tcse_pkg::COLOR_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == tcse_pkg::REG_BG) ?
                  {{(tcse_pkg::APB_DW - tcse_pkg::COLOR_W){1'b0}}, bg_color} :
                  {{(tcse_pkg::APB_DW - tcse_pkg::COLOR_W){1'b0}}, fg_color};

  tcse_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .kind (kind),
    .stat (stat),
    .ctl  (ctl),
    .busy (busy)
  );

  tcse_datapath #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .stat      (stat),
    .fg_color  (fg_color),
    .bg_color  (bg_color),
    .kind      (kind),
    .char_code (char_code),
    .position  (position),
    .done      (done),
    .cursor_now(cursor_now),
    .cell_data (cell_data),
    .scrolled  (scrolled)
  );

  // A result is shown only once the sequencer is back at idle.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while a command is still in progress");

  // A command is taken only at idle and finishes from a later step, so results never come back to back.
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("results in consecutive cycles");

  // A transfer always leaves the sequencer busy in the next cycle.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("command transfer did not start the sequencer");

  // A scroll always leaves the cursor at the start of the last row.
  assert property (@(posedge clk) disable iff (rst)
                   (done && scrolled) |-> (cursor_now == tcse_pkg::POS_W'(LAST)))
    else $error("scroll left the cursor away from the last row start");

endmodule

`default_nettype wire

// ----- tb/text_console_screen_checker.sv -----
`timescale 1ns / 1ps

module text_console_screen_checker #(
  parameter int COLUMNS = tcse_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcse_pkg::ROWS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic                        busy,
  input  wire logic [tcse_pkg::KIND_W-1:0] kind,
  input  wire logic [tcse_pkg::CHAR_W-1:0] char_code,
  input  wire logic [tcse_pkg::POS_W-1:0]  position,
  input  wire logic                        done,
  input  wire logic [tcse_pkg::POS_W-1:0]  cursor_now,
  input  wire logic [tcse_pkg::CELL_W-1:0] cell_data,
  input  wire logic                        scrolled,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tcse_pkg::APB_AW-1:0] paddr,
  input  wire logic [tcse_pkg::APB_DW-1:0] pwdata,
  input  wire logic                        pready,
  output int                               pending,
  output int                               fail_count
);

  import tcse_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;

  typedef struct packed {
    logic [POS_W-1:0]  cursor;
    logic [CELL_W-1:0] cell_val;
    logic              scrolled;
  } console_reply_t;

  // Shadow copy of the screen, the cursor and the colour registers.
  logic [CELL_W-1:0]  screen_model [CELLS];
  int unsigned        cursor_model;
  logic [COLOR_W-1:0] fg_model;
  logic [COLOR_W-1:0] bg_model;

  // Replies predicted for accepted commands, oldest first.
  console_reply_t console_replies_q [$];
  console_reply_t got_reply;
  console_reply_t want_reply;

  // Power-on state: white spaces on black, cursor at the top left.
  task automatic reset_screen_model();
    int i;
    for (i = 0; i < CELLS; i++) screen_model[i] = {RESET_ATTR, CH_SPACE};
    cursor_model = 0;
    fg_model     = RESET_ATTR[3:0];
    bg_model     = RESET_ATTR[7:4];
  endtask

  // Applies one command to the shadow screen and works out its reply.
  task automatic apply_console_cmd(input kind_t k, input logic [CHAR_W-1:0] ch,
                                   input logic [POS_W-1:0] pos,
                                   output console_reply_t r);
    logic [CELL_W-1:0] blank;
    int unsigned       c;
    int                i;
    blank = {bg_model, fg_model, CH_SPACE};
    r     = '0;
    c     = cursor_model;
    case (k)
      KIND_PUT: begin
        if (ch == CH_NEWLINE) begin
          c = (c / COLUMNS + 1) * COLUMNS;
        end else if (ch == CH_BACKSPACE) begin
          if (c > 0) begin
            c = c - 1;
            screen_model[c] = blank;
          end
        end else begin
          screen_model[c] = {bg_model, fg_model, ch};
          c = c + 1;
        end
        // Running off the end moves everything up a row.
        if (c >= CELLS) begin
          for (i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
          for (i = CELLS - COLUMNS; i < CELLS; i++) screen_model[i] = blank;
          c          = CELLS - COLUMNS;
          r.scrolled = 1'b1;
        end
      end
      KIND_CLEAR: begin
        for (i = 0; i < CELLS; i++) screen_model[i] = blank;
        c = 0;
      end
      KIND_SETCUR: begin
        c = (pos >= CELLS) ? CELLS - 1 : pos;
      end
      default: begin
        if (pos < CELLS) r.cell_val = screen_model[pos];
      end
    endcase
    cursor_model = c;
    r.cursor     = c[POS_W-1:0];
  endtask

  // Watch both channels and the register port at every rising edge.
  always @(posedge clk) begin
    if (rst) begin
      reset_screen_model();
      console_replies_q.delete();
    end else begin
      // Result transfer: compare with the oldest prediction.
      if (done) begin
        got_reply = '{cursor_now, cell_data, scrolled};
        if (console_replies_q.size() == 0) begin
          $error("result transfer with no command outstanding: cursor_now %0d", cursor_now);
          fail_count++;
        end else begin
          want_reply = console_replies_q.pop_front();
          if (got_reply.cursor !== want_reply.cursor) begin
            $error("cursor_now mismatch: expected %0d, actual %0d",
                   want_reply.cursor, got_reply.cursor);
            fail_count++;
          end
          if (got_reply.cell_val !== want_reply.cell_val) begin
            $error("cell_data mismatch: expected %h, actual %h",
                   want_reply.cell_val, got_reply.cell_val);
            fail_count++;
          end
          if (got_reply.scrolled !== want_reply.scrolled) begin
            $error("scrolled mismatch: expected %0d, actual %0d",
                   want_reply.scrolled, got_reply.scrolled);
            fail_count++;
          end
        end
      end
      // Command transfer: predict its reply.
      if (start && !busy) begin
        apply_console_cmd(kind_t'(kind), char_code, position, want_reply);
        console_replies_q.push_back(want_reply);
      end
      // Register write; the word address bit picks the colour.
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_FG) fg_model = pwdata[COLOR_W-1:0];
        else                    bg_model = pwdata[COLOR_W-1:0];
      end
    end
    pending = console_replies_q.size();
  end

endmodule

// ----- tb/text_console_screen_engine_tb.sv -----
`timescale 1ns / 1ps

module text_console_screen_engine_tb;

  import tcse_pkg::*;

  localparam int CELLS = COLUMNS_DEF * ROWS_DEF;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  kind_t               kind;
  logic [CHAR_W-1:0]   char_code;
  logic [POS_W-1:0]    position;
  logic                done;
  logic [POS_W-1:0]    cursor_now;
  logic [CELL_W-1:0]   cell_data;
  logic                scrolled;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  int                  pending;
  int                  fail_count;

  // Cursor target of the latest set-cursor, used to aim reads at written cells.
  int unsigned         last_target;
  int                  gap_pct;

  text_console_screen_engine u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .char_code  (char_code),
    .position   (position),
    .done       (done),
    .cursor_now (cursor_now),
    .cell_data  (cell_data),
    .scrolled   (scrolled),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  text_console_screen_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .char_code  (char_code),
    .position   (position),
    .done       (done),
    .cursor_now (cursor_now),
    .cell_data  (cell_data),
    .scrolled   (scrolled),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .pending    (pending),
    .fail_count (fail_count)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard limit on the run.
  initial begin
    #1_000_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Presents one command from a falling edge and holds it until its transfer.
  // Returns at the next falling edge with start still high.
  task automatic issue_cmd(input kind_t k, input logic [CHAR_W-1:0] ch,
                           input logic [POS_W-1:0] pos);
    start     = 1'b1;
    kind      = k;
    char_code = ch;
    position  = pos;
    if (k == KIND_SETCUR) last_target = pos;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops sending and waits for every outstanding reply.
  task automatic drain_replies();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // One APB write of a colour register, with junk in the unused data bits.
  task automatic write_colour_reg(input logic sel, input logic [COLOR_W-1:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {sel, 2'b00};
    pwdata  = ($urandom() & 32'hFFFF_FFF0) | APB_DW'(val);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Sets both colours between phases, once the block has gone quiet.
  task automatic set_colours(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
    drain_replies();
    write_colour_reg(REG_FG, fg);
    write_colour_reg(REG_BG, bg);
  endtask

  // One random command: mostly puts, with set-cursors often near the end of
  // the screen so that scrolls keep happening.
  task automatic random_cmd();
    int unsigned       pick;
    int unsigned       sub;
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  pos;
    pick = $urandom_range(99);
    sub  = $urandom_range(99);
    ch   = CHAR_W'($urandom_range(255));
    pos  = POS_W'($urandom_range(2047));
    if (pick < 58) begin
      if (sub < 8)       ch = CH_NEWLINE;
      else if (sub < 16) ch = CH_BACKSPACE;
      issue_cmd(KIND_PUT, ch, pos);
    end else if (pick < 60) begin
      issue_cmd(KIND_CLEAR, ch, pos);
    end else if (pick < 80) begin
      if (sub < 30) pos = POS_W'($urandom_range(CELLS - 1, CELLS - 100));
      issue_cmd(KIND_SETCUR, ch, pos);
    end else begin
      if (sub < 40) pos = POS_W'(((last_target + $urandom_range(79)) > 2047) ? 2047
                                 : last_target + $urandom_range(79));
      issue_cmd(KIND_READ, ch, pos);
    end
  endtask

  // Stimulus and verdict.
  initial begin
    int phase;
    int n;
    int wait_cycles;
    rst         = 1'b1;
    start       = 1'b0;
    kind        = KIND_PUT;
    char_code   = '0;
    position    = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    last_target = 0;
    gap_pct     = 35;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed part, at the power-on colours first.
    issue_cmd(KIND_READ,   8'h00, 11'd0);
    issue_cmd(KIND_PUT,    CH_BACKSPACE, 11'd0);   // backspace at the home cell
    issue_cmd(KIND_PUT,    8'h00, 11'h7FF);
    issue_cmd(KIND_PUT,    8'hFF, 11'd0);
    issue_cmd(KIND_PUT,    8'h41, 11'd0);
    issue_cmd(KIND_PUT,    CH_BACKSPACE, 11'd0);
    issue_cmd(KIND_PUT,    CH_NEWLINE, 11'd0);
    issue_cmd(KIND_READ,   8'hFF, 11'd1);
    issue_cmd(KIND_READ,   8'h00, 11'd2047);       // past the last cell
    issue_cmd(KIND_SETCUR, 8'h00, 11'd2047);       // saturates
    issue_cmd(KIND_PUT,    8'h5A, 11'd0);          // scrolls
    issue_cmd(KIND_READ,   8'h00, 11'd1919);
    issue_cmd(KIND_SETCUR, 8'h00, 11'd1950);
    issue_cmd(KIND_PUT,    CH_NEWLINE, 11'd0);     // newline on the last row scrolls
    issue_cmd(KIND_SETCUR, 8'h00, 11'd1999);
    issue_cmd(KIND_PUT,    CH_BACKSPACE, 11'd0);
    issue_cmd(KIND_READ,   8'h00, 11'd1998);
    issue_cmd(KIND_SETCUR, 8'hFF, 11'd0);
    issue_cmd(KIND_CLEAR,  8'hFF, 11'h7FF);
    issue_cmd(KIND_READ,   8'h00, 11'd1999);

    // Changed colours on puts, backspace and clear.
    set_colours(4'h0, 4'hF);
    issue_cmd(KIND_PUT,    8'h78, 11'd0);
    issue_cmd(KIND_PUT,    8'h79, 11'd0);
    issue_cmd(KIND_PUT,    CH_BACKSPACE, 11'd0);
    issue_cmd(KIND_READ,   8'h00, 11'd0);
    issue_cmd(KIND_READ,   8'h00, 11'd1);
    issue_cmd(KIND_CLEAR,  8'h00, 11'd0);
    issue_cmd(KIND_READ,   8'h00, 11'd1000);

    // Random part in phases, each with its own colour pair.
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       set_colours(4'hF, 4'h0);
        1:       set_colours(4'h0, 4'hF);
        2:       set_colours(4'h0, 4'h0);
        3:       set_colours(4'hF, 4'hF);
        default: set_colours(COLOR_W'($urandom_range(15)), COLOR_W'($urandom_range(15)));
      endcase
      // One phase runs flat out with no gaps.
      gap_pct = (phase == 1) ? 0 : 35;
      for (n = 0; n < 325; n++) begin
        if (gap_pct != 0 && $urandom_range(199) == 0) begin
          drain_replies();
        end else if ($urandom_range(99) < gap_pct) begin
          start = 1'b0;
          repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        random_cmd();
      end
    end
    start = 1'b0;

    // Let the last replies arrive, with a bound longer than a scroll.
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 50000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (8) @(negedge clk);
    if (pending == 0 && fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
